// ===== hw/rtl/rsr_pkg.sv =====
// shared types and constants for the record sort and rank block
// no dependencies; imported by every module of the block
package rsr_pkg;

    localparam int MAX_RECORDS = 16;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int ID_W        = 16;
    localparam int SCORE_W     = 7;
    localparam int RANK_W      = 5;
    localparam int RANK_MAX    = 31;
    localparam int MODE_W      = 2;

    // output order codes
    localparam logic [MODE_W-1:0] ORDER_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] ORDER_ID    = 2'd1;
    localparam logic [MODE_W-1:0] ORDER_SCORE = 2'd2;
    localparam logic [MODE_W-1:0] ORDER_RESET = ORDER_SCORE;

    typedef struct packed {
        logic [ID_W-1:0]    record_id;
        logic [SCORE_W-1:0] score;
        logic               batch_end;
    } in_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    out_id;
        logic [SCORE_W-1:0] out_score;
        logic [RANK_W-1:0]  rank;
        logic               out_last;
        logic               overflow;
    } out_word_t;

    // one stored record
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [RANK_W-1:0]  rank;
    } rec_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        rec_t             wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              go;
        logic [CNT_W-1:0]  n;
        logic [MODE_W-1:0] mode;
        logic              overflow;
    } seq_cmd_t;

endpackage

// ===== hw/rtl/rsr_ram.sv =====
// record memory: one write port, one read port, registered read data
// depends on rsr_pkg
module rsr_ram
    import rsr_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output rec_t     rdata
);

    rec_t mem [MAX_RECORDS];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rsr_seq.sv =====
// batch sequencer: rank pass, exchange sort pass and emit pass over the record memory
// depends on rsr_pkg; drives the read port and the sequencer side of the write port
module rsr_seq
    import rsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_cmd_t  cmd,
    input  rec_t      rdata,
    output ram_req_t  ram,
    output logic      busy,
    output logic      strobe,
    output out_word_t result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_RD,
        S_ROW_HOLD,
        S_SCAN,
        S_ROW_WB,
        S_EMIT_RD,
        S_EMIT
    } state_t;

    typedef enum logic {
        PH_RANK,
        PH_SORT
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              ovf_reg, ovf_next;
    rec_t              hold_reg, hold_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              strobe_reg, strobe_next;
    out_word_t         result_reg, result_next;

    logic              j_is_last;
    logic              rank_more;
    logic              sort_more;
    logic              sort_en;
    logic              swap;
    logic [CNT_W:0]    cnt_plus;
    logic [RANK_W-1:0] rank_val;
    logic [IDX_W-1:0]  j_start;

    assign j_is_last = (CNT_W'(j_reg) == n_reg - CNT_W'(1));
    assign rank_more = ((CNT_W+1)'(i_reg) + (CNT_W+1)'(1)) < (CNT_W+1)'(n_reg);
    assign sort_more = ((CNT_W+1)'(i_reg) + (CNT_W+1)'(2)) < (CNT_W+1)'(n_reg);
    assign sort_en   = ((mode_reg == ORDER_ID) || (mode_reg == ORDER_SCORE))
                       && (n_reg >= CNT_W'(2));
    assign cnt_plus  = (CNT_W+1)'(cnt_reg) + (CNT_W+1)'(1);
    assign rank_val  = (cnt_plus > (CNT_W+1)'(RANK_MAX)) ? RANK_W'(RANK_MAX)
                                                         : RANK_W'(cnt_plus);
    assign j_start   = (phase_reg == PH_RANK) ? '0 : i_reg + IDX_W'(1);

    // out-of-order test between the held entry i and the scanned entry j
    always_comb
    begin
        unique case (mode_reg)
            ORDER_ID:    swap = hold_reg.id > rdata.id;
            ORDER_SCORE: swap = hold_reg.score < rdata.score;
            default:     swap = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        mode_next   = mode_reg;
        ovf_next    = ovf_reg;
        hold_next   = hold_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        ram         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                begin
                    n_next     = cmd.n;
                    mode_next  = cmd.mode;
                    ovf_next   = cmd.overflow;
                    phase_next = PH_RANK;
                    i_next     = '0;
                    state_next = S_ROW_RD;
                end
            end
            S_ROW_RD:
            begin
                ram.raddr  = i_reg;
                state_next = S_ROW_HOLD;
            end
            S_ROW_HOLD:
            begin
                hold_next  = rdata;
                cnt_next   = '0;
                ram.raddr  = j_start;
                j_next     = j_start;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (phase_reg == PH_RANK)
                begin
                    if (rdata.score > hold_reg.score)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                else if (swap)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = j_reg;
                    ram.wdata = hold_reg;
                    hold_next = rdata;
                end
                if (j_is_last)
                begin
                    state_next = S_ROW_WB;
                end
                else
                begin
                    j_next    = j_reg + IDX_W'(1);
                    ram.raddr = j_reg + IDX_W'(1);
                end
            end
            S_ROW_WB:
            begin
                // write row i back and, while rows remain, read the next row in the same cycle
                ram.we    = 1'b1;
                ram.waddr = i_reg;
                ram.wdata = hold_reg;
                if (phase_reg == PH_RANK)
                begin
                    ram.wdata.rank = rank_val;
                end
                priority if ((phase_reg == PH_RANK) && rank_more)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    ram.raddr  = i_reg + IDX_W'(1);
                    state_next = S_ROW_HOLD;
                end
                else if ((phase_reg == PH_RANK) && sort_en)
                begin
                    phase_next = PH_SORT;
                    i_next     = '0;
                    ram.raddr  = '0;
                    state_next = S_ROW_HOLD;
                end
                else if ((phase_reg == PH_SORT) && sort_more)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    ram.raddr  = i_reg + IDX_W'(1);
                    state_next = S_ROW_HOLD;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                ram.raddr  = '0;
                j_next     = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                strobe_next           = 1'b1;
                result_next.out_id    = rdata.id;
                result_next.out_score = rdata.score;
                result_next.rank      = rdata.rank;
                result_next.out_last  = j_is_last;
                result_next.overflow  = ovf_reg;
                if (j_is_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next    = j_reg + IDX_W'(1);
                    ram.raddr = j_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_RANK;
            i_reg      <= '0;
            j_reg      <= '0;
            n_reg      <= '0;
            mode_reg   <= ORDER_RESET;
            ovf_reg    <= 1'b0;
            hold_reg   <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            n_reg      <= n_next;
            mode_reg   <= mode_next;
            ovf_reg    <= ovf_next;
            hold_reg   <= hold_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/record_sort_and_rank.sv =====
// top level of the record sort and rank block: load control, order register, memory
// depends on rsr_pkg, rsr_ram and rsr_seq
//
// usage
//   input words (record_id, score, batch_end) are taken at a rising edge with start high
//   and busy low. each word is written into the record memory in that cycle unless the
//   store is full, so loading runs at one word per cycle while busy stays low.
//   a word with batch_end closes the batch: busy rises on the next cycle and the
//   sequencer makes three passes over the memory
//     rank pass   each row scans every entry for higher scores
//     sort pass   exchange sort, only by id or by score, skipped for a single record
//     emit pass   one result word per cycle
//   the run time of a batch from close to last result is set by the single read port
//   of the record memory (one entry a cycle).
//   result words appear on result for one cycle each with strobe high, in the selected order,
//   the final one with out_last set; overflow is set on every word of a batch that
//   lost records to a full store. busy falls while the last word is shown.
//   the receiver cannot stall: results are never held back.
//   order_mode is written through cfg_we / cfg_data; the user writes it only while the
//   block is idle (not enforced). reset clears the record count, the drop flag and sets
//   order_mode to score descending; memory contents are left as they are.
module record_sort_and_rank
    import rsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  in_word_t          item,
    output logic              busy,
    output logic              strobe,
    output out_word_t         result,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_data
);

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              dropped_reg;

    logic              accept;
    logic              store_ok;
    logic              seq_busy;
    seq_cmd_t          cmd;
    ram_req_t          seq_req;
    ram_req_t          ram_req;
    rec_t              rdata;

    assign accept   = start && !seq_busy;
    assign store_ok = (count_reg < CNT_W'(MAX_RECORDS));
    assign busy     = seq_busy;

    // batch close hands the final count and drop state to the sequencer
    assign cmd.go       = accept && item.batch_end;
    assign cmd.n        = store_ok ? (count_reg + CNT_W'(1)) : count_reg;
    assign cmd.mode     = mode_reg;
    assign cmd.overflow = dropped_reg || !store_ok;

    // write port belongs to the load side while the sequencer is idle
    always_comb
    begin
        if (seq_busy)
        begin
            ram_req = seq_req;
        end
        else
        begin
            ram_req             = seq_req;
            ram_req.we          = accept && store_ok;
            ram_req.waddr       = count_reg[IDX_W-1:0];
            ram_req.wdata.id    = item.record_id;
            ram_req.wdata.score = item.score;
            ram_req.wdata.rank  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ORDER_RESET;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                if (item.batch_end)
                begin
                    count_reg   <= '0;
                    dropped_reg <= 1'b0;
                end
                else if (store_ok)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    rsr_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    rsr_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .rdata  (rdata),
        .ram    (seq_req),
        .busy   (seq_busy),
        .strobe (strobe),
        .result (result)
    );

endmodule

// ===== test/record_sort_and_rank_tb.sv =====
// self-checking testbench for record_sort_and_rank: batches of scored records in,
// ranked and reordered words out, checked against a cycle-free predictor
// depends on rsr_pkg and the record_sort_and_rank rtl
`timescale 1ns / 1ps

module record_sort_and_rank_tb;
    import rsr_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    // hard stop on simulated cycles; a few hundred batches at most
    localparam int CYCLE_LIMIT   = 400000;
    // quiet cycles after the last result word before touching the order register
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_WORDS   = 58;
    localparam int GAP_PERCENT   = 8;
    localparam int IN_W          = $bits(in_word_t);
    // order code with no meaning of its own, behaves like load order
    localparam logic [MODE_W-1:0] ORDER_UNUSED = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    in_word_t          item;
    logic              busy;
    logic              strobe;
    out_word_t         result;
    logic              cfg_we;
    logic [MODE_W-1:0] cfg_data;

    // predictor state: the records of the open batch and the selected order
    rec_t              held_recs [MAX_RECORDS];
    int                held_count;
    logic              held_dropped;
    logic [MODE_W-1:0] order_sel;

    // result words still owed by the block, oldest first
    out_word_t         expected_words [$];
    out_word_t         want;

    int                mismatch_count;
    int                cycle_count;
    bit                gaps_on;

    record_sort_and_rank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .strobe   (strobe),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // hard stop in case the block hangs or never drains
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("record_sort_and_rank_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // closes the open batch: competition ranks first, then the exchange sort
    // for the selected key, then one expected word per held record
    function automatic void rank_and_order_batch();
        rec_t      recs [MAX_RECORDS];
        rec_t      tmp;
        int        higher;
        bit        swap;
        out_word_t w;
        for (int i = 0; i < held_count; i++)
        begin
            higher = 1;
            for (int j = 0; j < held_count; j++)
                if (held_recs[j].score > held_recs[i].score)
                    higher++;
            recs[i]      = held_recs[i];
            recs[i].rank = (higher > RANK_MAX) ? RANK_MAX[RANK_W-1:0] : higher[RANK_W-1:0];
        end
        // equal keys never swap; load order and the unused code never swap at all
        for (int i = 0; i + 1 < held_count; i++)
        begin
            for (int j = i + 1; j < held_count; j++)
            begin
                swap = 1'b0;
                if (order_sel == ORDER_ID)
                    swap = recs[i].id > recs[j].id;
                else if (order_sel == ORDER_SCORE)
                    swap = recs[i].score < recs[j].score;
                if (swap)
                begin
                    tmp     = recs[i];
                    recs[i] = recs[j];
                    recs[j] = tmp;
                end
            end
        end
        for (int k = 0; k < held_count; k++)
        begin
            w.out_id    = recs[k].id;
            w.out_score = recs[k].score;
            w.rank      = recs[k].rank;
            w.out_last  = (k == held_count - 1);
            w.overflow  = held_dropped;
            expected_words.push_back(w);
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // one accepted input word: store it, or drop it once the store is full
    function automatic void take_word(input in_word_t w);
        if (held_count < MAX_RECORDS)
        begin
            held_recs[held_count].id    = w.record_id;
            held_recs[held_count].score = w.score;
            held_recs[held_count].rank  = '0;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (w.batch_end)
            rank_and_order_batch();
    endfunction

    // ---------------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0h got %0h", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // strobe and result are read just after the edge, so these are the values
    // that were shown during the cycle the edge closes
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none got %p",
                         $time, result);
                mismatch_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("out_id", 32'(want.out_id), 32'(result.out_id));
                check_field("out_score", 32'(want.out_score), 32'(result.out_score));
                check_field("rank", 32'(want.rank), 32'(result.rank));
                check_field("out_last", 32'(want.out_last), 32'(result.out_last));
                check_field("overflow", 32'(want.overflow), 32'(result.overflow));
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    function automatic in_word_t make_word(input logic [ID_W-1:0] id,
                                           input logic [SCORE_W-1:0] score,
                                           input logic last);
        in_word_t w;
        w.record_id = id;
        w.score     = score;
        w.batch_end = last;
        return w;
    endfunction

    // presents one word and holds it until the block takes it; start stays high
    // on return so back-to-back words need no extra cycle
    task automatic send_word(input in_word_t w);
        // each cycle idles at random with the gap odds
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            start <= 1'b0;
            // junk on the bus while start is low must be ignored
            item  <= IN_W'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        take_word(w);
    endtask

    // waits until every owed word has arrived and the block has gone quiet
    task automatic wait_for_idle();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_order(input logic [MODE_W-1:0] mode);
        wait_for_idle();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        order_sel = mode;
        cfg_we   <= 1'b0;
    endtask

    // a well-formed batch with random content; tie-heavy batches squeeze the
    // scores onto three values, and now and then an id repeats
    task automatic send_random_batch(input int size, input bit tie_heavy);
        in_word_t         w;
        logic [ID_W-1:0]  prev_id;
        prev_id = '0;
        for (int k = 0; k < size; k++)
        begin
            if (k > 0 && $urandom_range(0, 15) == 0)
                w.record_id = prev_id;
            else if ($urandom_range(0, 31) == 0)
                w.record_id = $urandom_range(0, 1) ? '1 : '0;
            else
                w.record_id = ID_W'($urandom);
            if (tie_heavy)
                w.score = SCORE_W'(50 * $urandom_range(0, 2));
            else
                w.score = SCORE_W'($urandom_range(0, 100));
            w.batch_end = (k == size - 1);
            send_word(w);
            prev_id = w.record_id;
        end
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // one record, extreme id and score, under the order selected by reset
    task automatic test_single_record();
        send_word(make_word('1, 7'd100, 1'b1));
    endtask

    // lowest and highest fields, a shared score and a repeated id in one batch
    task automatic test_ties_and_extremes();
        send_word(make_word(16'h0000, 7'd0, 1'b0));
        send_word(make_word(16'hFFFF, 7'd100, 1'b0));
        send_word(make_word(16'h1234, 7'd50, 1'b0));
        send_word(make_word(16'h1234, 7'd50, 1'b1));
    endtask

    // load order and the unused code both keep arrival order
    task automatic test_order_modes();
        set_order(ORDER_LOAD);
        send_word(make_word(16'h0009, 7'd10, 1'b0));
        send_word(make_word(16'h0003, 7'd90, 1'b1));
        set_order(ORDER_UNUSED);
        send_word(make_word(16'h0009, 7'd10, 1'b0));
        send_word(make_word(16'h0003, 7'd90, 1'b1));
    endtask

    // sixteen records fill the store; the closing word arrives with the store
    // full, so it is dropped yet still closes the batch with overflow set
    task automatic test_full_store();
        set_order(ORDER_ID);
        for (int k = 0; k < MAX_RECORDS; k++)
            send_word(make_word(16'((15 - k) * 16'h1111), 7'((k * 37) % 101), 1'b0));
        send_word(make_word(16'hABCD, 7'd99, 1'b1));
    endtask

    // mostly small batches, some at capacity, a few past it
    task automatic test_random_batches(input logic [MODE_W-1:0] mode, input int quota);
        int sent;
        int size;
        int pick;
        set_order(mode);
        sent = 0;
        while (sent < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                size = $urandom_range(1, 6);
            else if (pick < 85)
                size = $urandom_range(7, 15);
            else if (pick < 93)
                size = MAX_RECORDS;
            else
                size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
            send_random_batch(size, $urandom_range(0, 3) == 0);
            sent += size;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        held_count     = 0;
        held_dropped   = 1'b0;
        order_sel      = ORDER_RESET;
        mismatch_count = 0;
        cycle_count    = 0;
        gaps_on        = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_record();
        test_ties_and_extremes();
        test_order_modes();
        test_full_store();

        // first random phase runs without any idling on the input side
        gaps_on = 1'b0;
        test_random_batches(ORDER_LOAD, PHASE_WORDS);
        gaps_on = 1'b1;
        test_random_batches(ORDER_ID, PHASE_WORDS);
        test_random_batches(ORDER_UNUSED, PHASE_WORDS);
        test_random_batches(ORDER_SCORE, PHASE_WORDS);

        // drain, then watch a while longer for stray result words
        wait_for_idle();
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("record_sort_and_rank_tb: PASS");
        else
            $display("record_sort_and_rank_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rsr_pkg.sv
hw/rtl/rsr_ram.sv
hw/rtl/rsr_seq.sv
hw/rtl/record_sort_and_rank.sv
test/record_sort_and_rank_tb.sv
